[design/u2u_pkg.sv]
package u2u_pkg;

    localparam int unsigned BYTE_W = 8;
    localparam int unsigned CP_W   = 21;
    localparam int unsigned LEN_W  = 3;

    // sequence lengths, LEN_NONE = no sequence open
    localparam logic [LEN_W-1:0] LEN_NONE = 3'd0;
    localparam logic [LEN_W-1:0] LEN_ONE  = 3'd1;
    localparam logic [LEN_W-1:0] LEN_2    = 3'd2;
    localparam logic [LEN_W-1:0] LEN_3    = 3'd3;
    localparam logic [LEN_W-1:0] LEN_4    = 3'd4;

    localparam logic [CP_W-1:0] REPL_CP     = 21'h00FFFD;
    localparam logic [CP_W-1:0] CP_MAX      = 21'h10FFFF;
    localparam logic [CP_W-1:0] SURR_LO     = 21'h00D800;
    localparam logic [CP_W-1:0] SURR_HI     = 21'h00DFFF;
    localparam logic [CP_W-1:0] BMP_MAX     = 21'h00FFFF;
    localparam logic [CP_W-1:0] ASTRAL_BASE = 21'h010000;
    localparam logic [15:0]     HI_SURR_BASE = 16'hD800;
    localparam logic [15:0]     LO_SURR_BASE = 16'hDC00;

    // job queue between decoder and output sequencer
    localparam int unsigned QDEPTH = 4;
    localparam int unsigned QPTR_W = $clog2(QDEPTH);
    localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

    typedef struct packed {
        logic [CP_W-1:0] code_unit;
        logic            is_repl;
    } unit_t;

    // all results caused by one input item
    typedef struct packed {
        unit_t first;
        unit_t second;
        logic  two;   // second unit present
        logic  eot;   // item closed the text
    } job_t;

    typedef struct packed {
        logic seq_open;
        logic tail_run;
    } front_status_t;

endpackage

[design/u2u_front.sv]
module u2u_front (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        in_valid,
    input  logic                        q_ready,
    input  logic [7:0]                  text_byte,
    input  logic                        end_of_text,
    input  logic                        mode_cp,
    output logic                        push,
    output u2u_pkg::job_t               job,
    output u2u_pkg::front_status_t      status
);

    logic [u2u_pkg::CP_W-1:0]  part_reg, part_next;
    logic [u2u_pkg::LEN_W-1:0] len_reg, len_next;
    logic [u2u_pkg::LEN_W-1:0] taken_reg, taken_next;
    logic                      run_reg, run_next;

    logic                      accept;
    logic                      tail;
    logic [u2u_pkg::CP_W-1:0]  acc_shift;
    logic [u2u_pkg::LEN_W-1:0] taken_inc;

    // fresh decode of the byte
    logic                      f_emit, f_repl, f_tail;
    logic [u2u_pkg::CP_W-1:0]  f_cp, f_part;
    logic [u2u_pkg::LEN_W-1:0] f_len;

    // up to three code point events: break error, value, end-of-text flush
    logic                      e1_v, e2_v, e3_v, e2_repl, use_fresh;
    logic [u2u_pkg::CP_W-1:0]  e2_cp;
    logic                      astral;
    logic [u2u_pkg::CP_W-1:0]  astral_off;
    logic [1:0]                n_ev;
    u2u_pkg::unit_t            err_unit, val_unit;

    assign accept    = in_valid && q_ready;
    assign tail      = (text_byte[7:6] == 2'b10);
    assign acc_shift = {part_reg[u2u_pkg::CP_W-7:0], text_byte[5:0]};
    assign taken_inc = taken_reg + u2u_pkg::LEN_ONE;

    always_comb begin
        f_emit = 1'b0;
        f_repl = 1'b0;
        f_tail = 1'b0;
        f_cp   = '0;
        f_part = '0;
        f_len  = u2u_pkg::LEN_NONE;
        priority if (text_byte[7] == 1'b0) begin
            f_emit = 1'b1;
            f_cp   = {13'd0, text_byte};
        end else if (text_byte[7:5] == 3'b110) begin
            f_len  = u2u_pkg::LEN_2;
            f_part = {16'd0, text_byte[4:0]};
        end else if (text_byte[7:4] == 4'b1110) begin
            f_len  = u2u_pkg::LEN_3;
            f_part = {17'd0, text_byte[3:0]};
        end else if (text_byte[7:3] == 5'b11110) begin
            f_len  = u2u_pkg::LEN_4;
            f_part = {18'd0, text_byte[2:0]};
        end else if (tail) begin
            f_tail = 1'b1;
        end else begin
            // F8-FF
            f_emit = 1'b1;
            f_repl = 1'b1;
            f_cp   = u2u_pkg::REPL_CP;
        end
    end

    always_comb begin
        part_next  = part_reg;
        len_next   = len_reg;
        taken_next = taken_reg;
        run_next   = run_reg;
        e1_v       = 1'b0;
        e2_v       = 1'b0;
        e2_cp      = '0;
        e2_repl    = 1'b0;
        e3_v       = 1'b0;
        use_fresh  = 1'b0;

        priority if (len_reg != u2u_pkg::LEN_NONE) begin
            if (tail) begin
                if (taken_inc >= len_reg) begin
                    part_next  = '0;
                    len_next   = u2u_pkg::LEN_NONE;
                    taken_next = u2u_pkg::LEN_NONE;
                    e2_v       = 1'b1;
                    if (acc_shift > u2u_pkg::CP_MAX ||
                        (acc_shift >= u2u_pkg::SURR_LO && acc_shift <= u2u_pkg::SURR_HI)) begin
                        e2_cp   = u2u_pkg::REPL_CP;
                        e2_repl = 1'b1;
                    end else begin
                        e2_cp   = acc_shift;
                    end
                end else begin
                    part_next  = acc_shift;
                    taken_next = taken_inc;
                end
            end else begin
                e1_v      = 1'b1;
                use_fresh = 1'b1;
            end
        end else if (run_reg) begin
            if (!tail) begin
                e1_v      = 1'b1;
                use_fresh = 1'b1;
            end
        end else begin
            use_fresh = 1'b1;
        end

        if (use_fresh) begin
            e2_v       = f_emit;
            e2_cp      = f_cp;
            e2_repl    = f_repl;
            part_next  = f_part;
            len_next   = f_len;
            taken_next = (f_len != u2u_pkg::LEN_NONE) ? u2u_pkg::LEN_ONE : u2u_pkg::LEN_NONE;
            run_next   = f_tail;
        end

        if (end_of_text) begin
            e3_v       = (len_next != u2u_pkg::LEN_NONE) || run_next;
            part_next  = '0;
            len_next   = u2u_pkg::LEN_NONE;
            taken_next = u2u_pkg::LEN_NONE;
            run_next   = 1'b0;
        end
    end

    // build the units; at most two survive
    assign astral_off = e2_cp - u2u_pkg::ASTRAL_BASE;
    assign astral     = e2_v && !e2_repl && !mode_cp && (e2_cp > u2u_pkg::BMP_MAX);
    assign n_ev       = {1'b0, e1_v} + {1'b0, e2_v} + {1'b0, e3_v};
    assign err_unit   = '{code_unit: u2u_pkg::REPL_CP, is_repl: 1'b1};
    assign val_unit   = '{code_unit: e2_cp, is_repl: e2_repl};

    always_comb begin
        job.eot = end_of_text;
        if (astral) begin
            job.first  = '{code_unit: {5'd0, u2u_pkg::HI_SURR_BASE | {6'd0, astral_off[19:10]}},
                          is_repl: 1'b0};
            job.second = '{code_unit: {5'd0, u2u_pkg::LO_SURR_BASE | {6'd0, e2_cp[9:0]}},
                          is_repl: 1'b0};
            job.two    = 1'b1;
        end else begin
            job.first  = (!e1_v && e2_v) ? val_unit : err_unit;
            job.second = (e1_v && e2_v) ? val_unit : err_unit;
            job.two    = (n_ev >= 2'd2);
        end
    end

    assign push = accept && (n_ev != 2'd0);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            part_reg  <= '0;
            len_reg   <= u2u_pkg::LEN_NONE;
            taken_reg <= u2u_pkg::LEN_NONE;
            run_reg   <= 1'b0;
        end else if (accept) begin
            part_reg  <= part_next;
            len_reg   <= len_next;
            taken_reg <= taken_next;
            run_reg   <= run_next;
        end
    end

    assign status.seq_open = (len_reg != u2u_pkg::LEN_NONE);
    assign status.tail_run = run_reg;

endmodule

[design/u2u_queue.sv]
module u2u_queue (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  u2u_pkg::job_t push_job,
    output logic          not_full,
    input  logic          pop,
    output logic          head_valid,
    output u2u_pkg::job_t head_job
);

    u2u_pkg::job_t               mem_reg [u2u_pkg::QDEPTH];
    logic [u2u_pkg::QPTR_W-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [u2u_pkg::QCNT_W-1:0]  cnt_reg, cnt_next;
    logic                        do_push, do_pop;

    assign not_full   = (cnt_reg != u2u_pkg::QCNT_W'(u2u_pkg::QDEPTH));
    assign head_valid = (cnt_reg != '0);
    assign head_job   = mem_reg[rd_ptr_reg];
    assign do_push    = push && not_full;
    assign do_pop     = pop && head_valid;

    always_comb begin
        cnt_next = cnt_reg;
        unique case ({do_push, do_pop})
            2'b10:   cnt_next = cnt_reg + 1'b1;
            2'b01:   cnt_next = cnt_reg - 1'b1;
            default: cnt_next = cnt_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            cnt_reg <= cnt_next;
            if (do_push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

[design/u2u_back.sv]
module u2u_back (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      head_valid,
    input  u2u_pkg::job_t             head_job,
    output logic                      pop,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic [u2u_pkg::CP_W-1:0]  m_code_unit,
    output logic                      m_is_replacement,
    output logic                      m_last_of_run,
    output logic                      m_text_done
);

    logic                     valid_reg;
    logic                     idx_reg;
    logic [u2u_pkg::CP_W-1:0] unit_reg;
    logic                     repl_reg, last_reg, done_reg;
    logic                     load, last;
    u2u_pkg::unit_t           sel;

    assign load = head_valid && (!valid_reg || m_ready);
    assign last = !head_job.two || idx_reg;
    assign sel  = idx_reg ? head_job.second : head_job.first;
    assign pop  = load && last;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            idx_reg   <= 1'b0;
        end else if (load) begin
            valid_reg <= 1'b1;
            idx_reg   <= !last;
        end else if (m_ready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            unit_reg <= sel.code_unit;
            repl_reg <= sel.is_repl;
            last_reg <= last;
            done_reg <= last && head_job.eot;
        end
    end

    assign m_valid          = valid_reg;
    assign m_code_unit      = unit_reg;
    assign m_is_replacement = repl_reg;
    assign m_last_of_run    = last_reg;
    assign m_text_done      = done_reg;

endmodule

[design/utf8_to_utf16_transcoder.sv]
// Streaming UTF-8 decoder giving UTF-16 code units, or whole code points
// when cfg_data = 1 is written. One byte is taken per cycle on s_ while the
// 4-job queue between decoder and output sequencer has room; each byte's
// results (none, one or two) go into the queue as one job, and the
// sequencer sends one result per cycle on m_ while m_ready is high, so a
// byte that yields two units (surrogate pair, or U+FFFD followed by another
// result) sends them one after the other. Each result passes the job queue
// and the output register before it is valid on m_. Malformed input yields
// U+FFFD with m_is_replacement set; overlong forms are decoded as is.
// m_last_of_run marks the last result of a byte, m_text_done the last result
// of a byte marked s_end_of_text, after which the decoder is back to its
// reset state. Change the mode only while idle.
module utf8_to_utf16_transcoder (
    input  logic                      aclk,
    input  logic                      aresetn,
    // configuration
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic                      cfg_data,
    // byte input
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic [7:0]                s_text_byte,
    input  logic                      s_end_of_text,
    // unit output
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic [u2u_pkg::CP_W-1:0]  m_code_unit,
    output logic                      m_is_replacement,
    output logic                      m_last_of_run,
    output logic                      m_text_done
);

    logic                   mode_reg;
    logic                   q_push, q_pop, q_head_valid;
    u2u_pkg::job_t          q_in_job, q_head_job;
    u2u_pkg::front_status_t front_status;

    // mode register, write always taken
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= 1'b0;
        end else if (cfg_valid) begin
            mode_reg <= cfg_data;
        end
    end

    // decoder: byte classification and sequence state
    u2u_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (s_valid),
        .q_ready     (s_ready),
        .text_byte   (s_text_byte),
        .end_of_text (s_end_of_text),
        .mode_cp     (mode_reg),
        .push        (q_push),
        .job         (q_in_job),
        .status      (front_status)
    );

    // job queue decouples input from output stalls
    u2u_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_job   (q_in_job),
        .not_full   (s_ready),
        .pop        (q_pop),
        .head_valid (q_head_valid),
        .head_job   (q_head_job)
    );

    // output sequencer: one unit per cycle into the output register, held while m_ready is low
    u2u_back u_back (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .head_valid       (q_head_valid),
        .head_job         (q_head_job),
        .pop              (q_pop),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_code_unit      (m_code_unit),
        .m_is_replacement (m_is_replacement),
        .m_last_of_run    (m_last_of_run),
        .m_text_done      (m_text_done)
    );

    // end of text leaves no open sequence or tail run behind
    a_eot_flush: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_end_of_text |=> !front_status.seq_open && !front_status.tail_run)
        else $error("decoder state not cleared after end of text");

    // replacement units always carry U+FFFD
    a_repl_value: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_is_replacement |-> m_code_unit == u2u_pkg::REPL_CP)
        else $error("replacement item with wrong value");

    // text end only on the last result of a byte
    a_done_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_text_done |-> m_last_of_run)
        else $error("text end flagged before last result of its byte");

endmodule

[test/utf8_to_utf16_transcoder_tb.sv]
`timescale 1ns / 1ps

module utf8_to_utf16_transcoder_tb;
    import u2u_pkg::*;

    // one expected result item on the m_ side
    typedef struct packed {
        logic [CP_W-1:0] code_unit;
        logic            repl;
        logic            last;
        logic            done;
    } unit_exp_t;

    logic              aclk;
    logic              aresetn;
    logic              cfg_valid;
    logic              cfg_ready;
    logic              cfg_data;
    logic              s_valid;
    logic              s_ready;
    logic [7:0]        s_text_byte;
    logic              s_end_of_text;
    logic              m_valid;
    logic              m_ready;
    logic [CP_W-1:0]   m_code_unit;
    logic              m_is_replacement;
    logic              m_last_of_run;
    logic              m_text_done;

    // units still owed by the block, oldest first
    unit_exp_t         expected_units[$];
    // units worked out for the byte being decoded
    unit_exp_t         byte_units[2];
    int                byte_unit_cnt;

    // decoder state mirrored by the predictor
    logic              mode_cp;
    logic [CP_W-1:0]   acc_value;
    logic [LEN_W-1:0]  seq_len;
    logic [LEN_W-1:0]  seq_taken;
    logic              stray_run;

    // stimulus control
    logic [7:0]        text_buf[$];
    bit                tx_idle;
    bit                rx_idle;
    int                hold_len;
    int                bytes_sent;
    int                mismatch_count;

    utf8_to_utf16_transcoder uut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_data         (cfg_data),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_text_byte      (s_text_byte),
        .s_end_of_text    (s_end_of_text),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_code_unit      (m_code_unit),
        .m_is_replacement (m_is_replacement),
        .m_last_of_run    (m_last_of_run),
        .m_text_done      (m_text_done)
    );

    always begin
        aclk = 1'b0;
        #10;
        aclk = 1'b1;
        #10;
    end

    // -------------------------------------------------------------------
    // Decoder prediction
    // -------------------------------------------------------------------

    // at most two units per byte, anything beyond is dropped
    function automatic void add_unit(logic [CP_W-1:0] v, logic repl);
        if (byte_unit_cnt < 2) begin
            byte_units[byte_unit_cnt] = '{code_unit: v, repl: repl, last: 1'b0, done: 1'b0};
            byte_unit_cnt++;
        end
    endfunction

    // whole code point, or a surrogate pair for astral values in UTF-16 mode
    function automatic void add_code_point(logic [CP_W-1:0] cp, logic repl);
        logic [CP_W-1:0] off;
        logic [CP_W-1:0] hi;
        logic [CP_W-1:0] lo;
        if (mode_cp || cp <= BMP_MAX) begin
            add_unit(cp, repl);
        end else begin
            off = cp - ASTRAL_BASE;
            hi = '0;
            lo = '0;
            hi[15:0] = HI_SURR_BASE | {6'b0, off[19:10]};
            lo[15:0] = LO_SURR_BASE | {6'b0, cp[9:0]};
            add_unit(hi, repl);
            add_unit(lo, repl);
        end
    endfunction

    function automatic void add_error();
        add_code_point(REPL_CP, 1'b1);
    endfunction

    function automatic void close_seq();
        acc_value = '0;
        seq_len   = LEN_NONE;
        seq_taken = LEN_NONE;
    endfunction

    // byte seen with no sequence open
    function automatic void fresh_decode(logic [7:0] b);
        if (!b[7]) begin
            add_code_point({13'b0, b}, 1'b0);
        end else if (b[7:5] == 3'b110) begin
            acc_value = {16'b0, b[4:0]};
            seq_len   = LEN_2;
            seq_taken = LEN_ONE;
        end else if (b[7:4] == 4'b1110) begin
            acc_value = {17'b0, b[3:0]};
            seq_len   = LEN_3;
            seq_taken = LEN_ONE;
        end else if (b[7:3] == 5'b11110) begin
            acc_value = {18'b0, b[2:0]};
            seq_len   = LEN_4;
            seq_taken = LEN_ONE;
        end else if (b[7:6] == 2'b10) begin
            stray_run = 1'b1;
        end else begin
            add_error();
        end
    endfunction

    // advance the mirrored decoder by one accepted byte and queue its units
    function automatic void predict_byte(logic [7:0] b, logic eot);
        logic            tail;
        logic [CP_W-1:0] v;
        byte_unit_cnt = 0;
        tail = (b[7:6] == 2'b10);
        if (seq_len != LEN_NONE) begin
            if (tail) begin
                acc_value = {acc_value[CP_W-7:0], b[5:0]};
                seq_taken = seq_taken + 1'b1;
                if (seq_taken >= seq_len) begin
                    v = acc_value;
                    close_seq();
                    if (v > CP_MAX || (v >= SURR_LO && v <= SURR_HI))
                        add_error();
                    else
                        add_code_point(v, 1'b0);
                end
            end else begin
                // broken sequence: report it, then treat the byte as new
                close_seq();
                add_error();
                fresh_decode(b);
            end
        end else if (stray_run) begin
            if (!tail) begin
                stray_run = 1'b0;
                add_error();
                fresh_decode(b);
            end
        end else begin
            fresh_decode(b);
        end

        // end of text flushes whatever is still open
        if (eot) begin
            if (seq_len != LEN_NONE) begin
                close_seq();
                add_error();
            end
            if (stray_run) begin
                stray_run = 1'b0;
                add_error();
            end
        end

        for (int i = 0; i < byte_unit_cnt; i++) begin
            if (i == byte_unit_cnt - 1) begin
                byte_units[i].last = 1'b1;
                byte_units[i].done = eot;
            end
            expected_units.push_back(byte_units[i]);
        end
    endfunction

    // -------------------------------------------------------------------
    // Driving and checking
    // -------------------------------------------------------------------

    task automatic note_failure(string msg);
        mismatch_count++;
        $display("%0t: %s", $realtime, msg);
    endtask

    // one byte on s_; returns at the edge where it was taken
    task automatic send_byte(logic [7:0] b, logic eot);
        int gap;
        gap = tx_idle ? $urandom_range(0, 6) : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_text_byte   <= b;
        s_end_of_text <= eot;
        do @(posedge aclk); while (!s_ready);
        predict_byte(b, eot);
        bytes_sent++;
    endtask

    // sends text_buf, end-of-text on its last byte if close_text is set
    task automatic send_text(bit close_text);
        for (int i = 0; i < text_buf.size(); i++)
            send_byte(text_buf[i], close_text && (i == text_buf.size() - 1));
        text_buf.delete();
    endtask

    task automatic pause_for_results();
        s_valid <= 1'b0;
        while (expected_units.size() != 0)
            @(posedge aclk);
    endtask

    // bytes with no result may still be in flight after the last unit
    task automatic wait_idle();
        pause_for_results();
        repeat (8) @(posedge aclk);
    endtask

    task automatic write_mode(logic m);
        cfg_valid <= 1'b1;
        cfg_data  <= m;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        mode_cp = m;
    endtask

    // lead of the given length plus tails, random payload bits;
    // only the first keep bytes are queued (fewer gives a cut sequence)
    function automatic void append_sequence(int len, int keep);
        logic [31:0] r;
        logic [7:0]  seq_bytes[4];
        r = $urandom;
        case (len)
            1: seq_bytes[0] = {1'b0, r[6:0]};
            2: seq_bytes[0] = {3'b110, r[4:0]};
            3: seq_bytes[0] = {4'b1110, r[3:0]};
            default: seq_bytes[0] = {5'b11110, r[2:0]};
        endcase
        for (int i = 1; i < 4; i++) begin
            r = $urandom;
            seq_bytes[i] = {2'b10, r[5:0]};
        end
        for (int i = 0; i < keep; i++)
            text_buf.push_back(seq_bytes[i]);
    endfunction

    // mostly well-formed characters, with cut sequences, noise bytes and
    // stray tail runs mixed in
    function automatic void build_random_text(int n_chars);
        int kind;
        int len;
        for (int c = 0; c < n_chars; c++) begin
            kind = $urandom_range(0, 99);
            if (kind < 70) begin
                len = $urandom_range(1, 4);
                append_sequence(len, len);
            end else if (kind < 80) begin
                len = $urandom_range(2, 4);
                append_sequence(len, $urandom_range(1, len - 1));
            end else if (kind < 90) begin
                text_buf.push_back(8'($urandom_range(0, 255)));
            end else begin
                repeat ($urandom_range(1, 3))
                    text_buf.push_back({2'b10, 6'($urandom_range(0, 63))});
            end
        end
    endfunction

    // -------------------------------------------------------------------
    // Receiver: random stalls, long hold-off on request, checks each item
    // -------------------------------------------------------------------

    task automatic check_unit();
        unit_exp_t want;
        if (expected_units.size() == 0) begin
            note_failure($sformatf("unit %0h with nothing expected", m_code_unit));
        end else begin
            want = expected_units.pop_front();
            if (m_code_unit !== want.code_unit)
                note_failure($sformatf("code_unit %0h, want %0h",
                                       m_code_unit, want.code_unit));
            if (m_is_replacement !== want.repl)
                note_failure($sformatf("is_replacement %0b, want %0b",
                                       m_is_replacement, want.repl));
            if (m_last_of_run !== want.last)
                note_failure($sformatf("last_of_run %0b, want %0b",
                                       m_last_of_run, want.last));
            if (m_text_done !== want.done)
                note_failure($sformatf("text_done %0b, want %0b",
                                       m_text_done, want.done));
        end
    endtask

    initial begin : unit_receiver
        int stall;
        m_ready <= 1'b0;
        while (aresetn !== 1'b1) @(posedge aclk);
        forever begin
            stall = rx_idle ? $urandom_range(0, 6) : 0;
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            forever begin
                @(posedge aclk);
                if (m_valid && m_ready)
                    break;
                // long hold-off, counted here so the sender keeps pushing
                if (hold_len > 0) begin
                    m_ready <= 1'b0;
                    repeat (hold_len) @(posedge aclk);
                    hold_len = 0;
                    m_ready <= 1'b1;
                end
            end
            check_unit();
        end
    end

    // -------------------------------------------------------------------
    // Tests
    // -------------------------------------------------------------------

    // extremes of the byte, every sequence length and every error case
    task automatic test_directed_utf16();
        write_mode(1'b0);
        tx_idle = 1'b0;
        rx_idle = 1'b0;
        text_buf = '{8'h00, 8'h7F};                  // ASCII extremes
        send_text(1'b0);
        text_buf = '{8'hC0, 8'h80};                  // overlong NUL, accepted
        send_text(1'b0);
        text_buf = '{8'hE2, 8'h82, 8'hAC};           // three-byte form
        send_text(1'b0);
        text_buf = '{8'hF0, 8'h9F, 8'h98, 8'h80};    // astral, surrogate pair
        send_text(1'b0);
        text_buf = '{8'hBF, 8'h80, 8'h41};           // stray tail run, then 'A'
        send_text(1'b0);
        text_buf = '{8'hC3, 8'h41};                  // lead broken by ASCII
        send_text(1'b0);
        text_buf = '{8'hF8, 8'hFF};                  // invalid leads
        send_text(1'b0);
        text_buf = '{8'hED, 8'hA0, 8'h80};           // encoded surrogate
        send_text(1'b0);
        text_buf = '{8'hF4, 8'h90, 8'h80, 8'h80};    // above U+10FFFF
        send_text(1'b0);
        text_buf = '{8'hE2, 8'h82};                  // cut by end of text
        send_text(1'b1);
        text_buf = '{8'h80};                         // tail run at end of text
        send_text(1'b1);
        wait_idle();
    endtask

    task automatic test_code_point_mode();
        write_mode(1'b1);
        tx_idle = 1'b1;
        rx_idle = 1'b1;
        // astral and the top of the code space come out whole
        text_buf = '{8'hF0, 8'h9F, 8'h98, 8'h80, 8'hF4, 8'h8F, 8'hBF, 8'hBF, 8'h41};
        send_text(1'b1);
        repeat (6) begin
            build_random_text($urandom_range(1, 8));
            send_text(1'b1);
        end
        wait_idle();
        write_mode(1'b0);
    endtask

    // receiver holds off while astral text streams in, so the block fills
    // and drops s_ready; then the sender waits mid-sequence for all units
    task automatic test_backpressure();
        tx_idle = 1'b0;
        rx_idle = 1'b0;
        hold_len = 80;
        repeat (12) append_sequence(4, 4);
        send_text(1'b0);
        text_buf = '{8'hF0, 8'h9F};
        send_text(1'b0);
        pause_for_results();
        tx_idle = 1'b1;
        rx_idle = 1'b1;
        text_buf = '{8'h98, 8'h80, 8'h41};
        send_text(1'b1);
        wait_idle();
    endtask

    task automatic test_random_texts(int n_bytes);
        int start;
        start = bytes_sent;
        while (bytes_sent - start < n_bytes) begin
            // stretches without idling on either side now and then
            tx_idle = ($urandom_range(0, 3) != 0);
            rx_idle = ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 7) == 0) begin
                wait_idle();
                write_mode(1'($urandom_range(0, 1)));
            end
            build_random_text($urandom_range(0, 4) == 0 ? 1 : $urandom_range(2, 12));
            // a text is sometimes left open across the next one
            send_text($urandom_range(0, 5) != 0);
        end
        text_buf = '{8'h41};
        send_text(1'b1);
        wait_idle();
    endtask

    initial begin : run_tests
        int waited;
        aresetn       <= 1'b0;
        cfg_valid     <= 1'b0;
        cfg_data      <= 1'b0;
        s_valid       <= 1'b0;
        s_text_byte   <= 8'h00;
        s_end_of_text <= 1'b0;
        tx_idle        = 1'b0;
        rx_idle        = 1'b0;
        hold_len       = 0;
        bytes_sent     = 0;
        mismatch_count = 0;
        mode_cp        = 1'b0;
        stray_run      = 1'b0;
        close_seq();
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed_utf16();
        test_code_point_mode();
        test_backpressure();
        test_random_texts(260);

        s_valid <= 1'b0;
        waited = 0;
        while (expected_units.size() != 0 && waited < 5000) begin
            @(posedge aclk);
            waited++;
        end
        if (expected_units.size() != 0)
            note_failure($sformatf("%0d units never arrived", expected_units.size()));
        repeat (8) @(posedge aclk);
        if (mismatch_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    // watchdog, far beyond the slowest legal run
    initial begin
        #5000000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
